>>> rtl/adf_pkg.sv
package adf_pkg;

  localparam int CharW            = 8;
  localparam int WholeW           = 31;
  localparam int QuotW            = 32;
  localparam int PowW             = 34;
  localparam int DigitW           = 4;
  localparam int MaxFracDigitsDef = 10;

  localparam logic [CharW-1:0]  CharDot  = 8'h2E;
  localparam logic [CharW-1:0]  CharZero = 8'h30;
  localparam logic [CharW-1:0]  CharNine = 8'h39;
  localparam logic [WholeW-1:0] WholeMax = {WholeW{1'b1}};

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // ten to the power n, n in 0..10
  function automatic logic [PowW-1:0] pow_ten(input int n);
    logic [PowW-1:0] p;
    case (n)
      0:       p = 34'd1;
      1:       p = 34'd10;
      2:       p = 34'd100;
      3:       p = 34'd1000;
      4:       p = 34'd10000;
      5:       p = 34'd100000;
      6:       p = 34'd1000000;
      7:       p = 34'd10000000;
      8:       p = 34'd100000000;
      9:       p = 34'd1000000000;
      default: p = 34'd10000000000;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/adf_if.sv
interface adf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface adf_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] integer_part;
  logic [31:0] fraction_part;
  logic        integer_overflow;
  logic        fraction_truncated;

  modport source (output valid, output integer_part, output fraction_part,
                  output integer_overflow, output fraction_truncated, input ready);
  modport sink   (input valid, input integer_part, input fraction_part,
                  input integer_overflow, input fraction_truncated, output ready);
endinterface

>>> rtl/adf_divider.sv
module adf_divider #(
  parameter int FRAC_W = 34,
  parameter int DIG_W  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FRAC_W-1:0]    num_i,
  input  logic [DIG_W-1:0]     digits_i,
  output adf_pkg::div_status_t status_o,
  output logic [31:0]          quot_o
);
  import adf_pkg::*;

  localparam int CntW = $clog2(QuotW);

  logic [FRAC_W-1:0] rem_q, rem_d;
  logic [FRAC_W-1:0] den_q, den_d;
  logic [QuotW-1:0]  quot_q, quot_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [PowW-1:0]   pow_w;
  logic [FRAC_W:0]   rem_sh;
  logic [FRAC_W:0]   rem_sub;
  logic              take;

  assign pow_w   = pow_ten(int'(digits_i));
  assign rem_sh  = {rem_q, 1'b0};
  assign take    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      den_d  = pow_w[FRAC_W-1:0];
      cnt_d  = CntW'(QuotW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = take ? rem_sub[FRAC_W-1:0] : rem_sh[FRAC_W-1:0];
      quot_d = {quot_q[QuotW-2:0], take};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < den_q) else $error("remainder not below divisor");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("done without a run");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("start while busy");

endmodule

>>> rtl/ascii_decimal_to_fixed_point.sv
// Parses an unsigned decimal number sent one ASCII character per request, with
// last_char set on the final one. Digits before the first dot build a saturating
// 31-bit integer part; up to MAX_FRAC_DIGITS digits after it build the fraction,
// further ones are dropped and flagged. Any other character counts as digit 0.
// Ordinary characters are taken back to back while idle. The final character starts a
// restoring divider that yields the fraction as unsigned Q0.32, one quotient bit
// per cycle through a single compare-and-subtract unit. The result is offered
// once the divider is done, later if the previous result is still waiting.
// The input is held off until the result moves to the output register. A
// waiting result does not block ordinary characters of the next number.
module ascii_decimal_to_fixed_point #(
  parameter int MAX_FRAC_DIGITS = adf_pkg::MaxFracDigitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  adf_in_if.sink    in_i,
  adf_out_if.source out_o
);
  import adf_pkg::*;

  localparam int FracW = $clog2(pow_ten(MAX_FRAC_DIGITS));
  localparam int DigW  = $clog2(MAX_FRAC_DIGITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [WholeW-1:0] whole_q, whole_d;
  logic [FracW-1:0]  frac_q, frac_d;
  logic [DigW-1:0]   digits_q, digits_d;
  logic              dot_q, dot_d;
  logic              sat_q, sat_d;
  logic              cut_q, cut_d;

  logic [WholeW-1:0] res_whole_q, res_whole_d;
  logic              res_sat_q, res_sat_d;
  logic              res_cut_q, res_cut_d;

  logic              out_valid_q, out_valid_d;
  logic [WholeW-1:0] out_whole_q, out_whole_d;
  logic [QuotW-1:0]  out_frac_q, out_frac_d;
  logic              out_sat_q, out_sat_d;
  logic              out_cut_q, out_cut_d;

  logic              in_acc;
  logic              is_digit;
  logic [CharW-1:0]  ch_off;
  logic [DigitW-1:0] digit;
  logic [WholeW+3:0] whole_mul;
  logic [FracW+3:0]  frac_mul;
  logic              out_free;
  logic              div_start;
  logic [QuotW-1:0]  quot;
  div_status_t       div_st;

  // accumulator updates for the incoming character
  logic [WholeW-1:0] whole_nx;
  logic [FracW-1:0]  frac_nx;
  logic [DigW-1:0]   digits_nx;
  logic              dot_nx, sat_nx, cut_nx;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign is_digit  = (in_i.char_code >= CharZero) && (in_i.char_code <= CharNine);
  assign ch_off    = in_i.char_code - CharZero;
  assign digit     = is_digit ? ch_off[DigitW-1:0] : '0;
  assign whole_mul = ({4'b0, whole_q} << 3) + ({4'b0, whole_q} << 1)
                   + (WholeW+4)'(digit);
  assign frac_mul  = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1)
                   + (FracW+4)'(digit);

  always_comb begin
    whole_nx  = whole_q;
    frac_nx   = frac_q;
    digits_nx = digits_q;
    dot_nx    = dot_q;
    sat_nx    = sat_q;
    cut_nx    = cut_q;
    if (in_i.char_code == CharDot && !dot_q) begin
      dot_nx = 1'b1;
    end else if (dot_q) begin
      if (digits_q < DigW'(MAX_FRAC_DIGITS)) begin
        frac_nx   = frac_mul[FracW-1:0];
        digits_nx = digits_q + 1'b1;
      end else begin
        cut_nx = 1'b1;
      end
    end else if (whole_mul > {4'b0, WholeMax}) begin
      whole_nx = WholeMax;
      sat_nx   = 1'b1;
    end else begin
      whole_nx = whole_mul[WholeW-1:0];
    end
  end

  assign div_start = in_acc && in_i.last_char;

  always_comb begin
    state_d     = state_q;
    whole_d     = whole_q;
    frac_d      = frac_q;
    digits_d    = digits_q;
    dot_d       = dot_q;
    sat_d       = sat_q;
    cut_d       = cut_q;
    res_whole_d = res_whole_q;
    res_sat_d   = res_sat_q;
    res_cut_d   = res_cut_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_whole_d = out_whole_q;
    out_frac_d  = out_frac_q;
    out_sat_d   = out_sat_q;
    out_cut_d   = out_cut_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.last_char) begin
            res_whole_d = whole_nx;
            res_sat_d   = sat_nx;
            res_cut_d   = cut_nx;
            whole_d     = '0;
            frac_d      = '0;
            digits_d    = '0;
            dot_d       = 1'b0;
            sat_d       = 1'b0;
            cut_d       = 1'b0;
            state_d     = ST_DIV;
          end else begin
            whole_d  = whole_nx;
            frac_d   = frac_nx;
            digits_d = digits_nx;
            dot_d    = dot_nx;
            sat_d    = sat_nx;
            cut_d    = cut_nx;
          end
        end
      end
      ST_DIV, ST_OUT: begin
        if ((state_q == ST_OUT || div_st.done) && out_free) begin
          out_valid_d = 1'b1;
          out_whole_d = res_whole_q;
          out_frac_d  = quot;
          out_sat_d   = res_sat_q;
          out_cut_d   = res_cut_q;
          state_d     = ST_IDLE;
        end else if (div_st.done) begin
          state_d = ST_OUT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      whole_q     <= '0;
      frac_q      <= '0;
      digits_q    <= '0;
      dot_q       <= 1'b0;
      sat_q       <= 1'b0;
      cut_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      whole_q     <= whole_d;
      frac_q      <= frac_d;
      digits_q    <= digits_d;
      dot_q       <= dot_d;
      sat_q       <= sat_d;
      cut_q       <= cut_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_whole_q <= res_whole_d;
    res_sat_q   <= res_sat_d;
    res_cut_q   <= res_cut_d;
    out_whole_q <= out_whole_d;
    out_frac_q  <= out_frac_d;
    out_sat_q   <= out_sat_d;
    out_cut_q   <= out_cut_d;
  end

  adf_divider #(
    .FRAC_W (FracW),
    .DIG_W  (DigW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (frac_nx),
    .digits_i (digits_nx),
    .status_o (div_st),
    .quot_o   (quot)
  );

  assign out_o.valid              = out_valid_q;
  assign out_o.integer_part       = out_whole_q;
  assign out_o.fraction_part      = out_frac_q;
  assign out_o.integer_overflow   = out_sat_q;
  assign out_o.fraction_truncated = out_cut_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == ST_DIV) else $error("divider done outside run");
  a_last_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_st.busy && whole_q == '0 && frac_q == '0 && digits_q == '0)
    else $error("final character did not start division and clear state");
  a_digits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_q <= DigW'(MAX_FRAC_DIGITS)) else $error("fraction digit count overrun");
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> !in_i.ready) else $error("input taken during division");

endmodule

>>> tb/tb_ascii_decimal_to_fixed_point.sv
`timescale 1ns / 100ps

module tb_ascii_decimal_to_fixed_point;
  import adf_pkg::*;

  localparam int FracDigitsMax = MaxFracDigitsDef;
  localparam int DrainCycles   = 48;
  localparam int WatchdogLimit = 3000;
  localparam int HoldOffCycles = 400;
  localparam int MaxPrinted    = 40;

  typedef logic [CharW-1:0] char_q_t[$];

  typedef struct packed {
    logic [WholeW-1:0] integer_part;
    logic [QuotW-1:0]  fraction_part;
    logic              integer_overflow;
    logic              fraction_truncated;
  } fixed_result_t;

  logic clk_i;
  logic rst_ni;

  adf_in_if  in_if ();
  adf_out_if out_if ();

  ascii_decimal_to_fixed_point dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // parser state as the block should hold it
  logic [WholeW-1:0] int_acc;
  logic [PowW-1:0]   fr_acc;
  logic [DigitW-1:0] fr_count;
  logic              got_dot;
  logic              int_clipped;
  logic              fr_dropped;

  fixed_result_t pending_values[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int idle_cycles;
  int mismatches;
  int chars_sent;
  int numbers_parsed;
  int clipped_seen;
  int dropped_seen;

  always #5 clk_i = ~clk_i;

  // floor(num * 2^32 / 10^n), bit by bit
  function automatic logic [QuotW-1:0] scale_fraction(logic [63:0] num, int n);
    logic [63:0]      den;
    logic [63:0]      rem;
    logic [QuotW-1:0] q;
    den = 64'd1;
    q   = '0;
    if (n == 0) return '0;
    for (int i = 0; i < n; i++) den = den * 64'd10;
    rem = num % den;
    for (int i = 0; i < QuotW; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem  = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  task automatic clear_parser();
    int_acc     = '0;
    fr_acc      = '0;
    fr_count    = '0;
    got_dot     = 1'b0;
    int_clipped = 1'b0;
    fr_dropped  = 1'b0;
  endtask

  task automatic parse_char(input logic [CharW-1:0] ch, input logic last);
    logic [63:0]   digit;
    logic [63:0]   wide;
    fixed_result_t res;
    digit = (ch >= CharZero && ch <= CharNine) ? 64'(ch - CharZero) : 64'd0;
    if (ch == CharDot && !got_dot) begin
      got_dot = 1'b1;
    end else if (got_dot) begin
      if (fr_count < FracDigitsMax) begin
        fr_acc   = PowW'(fr_acc * 64'd10 + digit);
        fr_count = fr_count + 1'b1;
      end else begin
        fr_dropped = 1'b1;
      end
    end else begin
      wide = 64'(int_acc) * 64'd10 + digit;
      if (wide > 64'(WholeMax)) begin
        int_acc     = WholeMax;
        int_clipped = 1'b1;
      end else begin
        int_acc = WholeW'(wide);
      end
    end
    if (last) begin
      res.integer_part       = int_acc;
      res.fraction_part      = scale_fraction(64'(fr_acc), int'(fr_count));
      res.integer_overflow   = int_clipped;
      res.fraction_truncated = fr_dropped;
      pending_values.push_back(res);
      numbers_parsed++;
      if (int_clipped) clipped_seen++;
      if (fr_dropped) dropped_seen++;
      clear_parser();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MaxPrinted)
      $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // one request on the input channel; predicts on acceptance
  task automatic send_char(input logic [CharW-1:0] ch, input logic last);
    @(negedge clk_i);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= ch;
    in_if.last_char <= last;
    do @(posedge clk_i); while (!in_if.ready);
    chars_sent++;
    parse_char(ch, last);
  endtask

  task automatic send_number(input char_q_t chars);
    for (int i = 0; i < chars.size(); i++) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (pending_values.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mostly well-formed numbers, some corrupted, some pure junk
  task automatic make_number(output char_q_t chars);
    int n_int;
    int n_frac;
    chars = {};
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) chars.push_back(CharW'($urandom_range(255)));
      return;
    end
    n_int  = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
    n_frac = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6);
    repeat (n_int) chars.push_back(CharW'(CharZero + $urandom_range(9)));
    // land near the saturation point now and then
    if (n_int == 10 && $urandom_range(1) == 1) begin
      chars[0] = CharW'(CharZero + 2);
      chars[1] = CharW'(CharZero + 1);
    end
    if ($urandom_range(3) != 0) begin
      chars.push_back(CharDot);
      repeat (n_frac) chars.push_back(CharW'(CharZero + $urandom_range(9)));
    end
    if (chars.size() == 0) chars.push_back(CharW'(CharZero + $urandom_range(9)));
    if ($urandom_range(4) == 0)
      chars[$urandom_range(chars.size() - 1)] = CharW'($urandom_range(255));
  endtask

  task automatic run_random(input int n_chars);
    char_q_t c;
    int      sent;
    sent = 0;
    while (sent < n_chars) begin
      make_number(c);
      send_number(c);
      sent += c.size();
    end
  endtask

  task automatic test_directed();
    char_q_t c;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // clipped whole part, full fraction, an extra non-digit dropped at the end
    c = {};
    repeat (10) c.push_back(8'h39);
    c.push_back(CharDot);
    repeat (10) c.push_back(8'h39);
    c.push_back(8'hFF);
    send_number(c);
    c = '{8'h35, CharDot};   // trailing dot
    send_number(c);
    c = '{CharDot, CharDot}; // second dot is a zero digit
    send_number(c);
    c = '{CharDot, 8'h35};
    send_number(c);
    c = '{8'h00};
    send_number(c);
    wait_drained();
  endtask

  task automatic test_streaming();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(280);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct  = 51;
    recv_stall_pct = 0;
    run_random(280);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    run_random(280);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    run_random(280);
  endtask

  // output held off while input keeps coming, so the input backs up
  task automatic test_receiver_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HoldOffCycles;
    run_random(100);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    char_q_t c;
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    repeat (6) begin
      make_number(c);
      send_number(c);
      wait_drained();
    end
  endtask

  // receiver side
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    fixed_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_values.size() == 0) begin
        report_mismatch("result with none expected", 32'(out_if.integer_part), '0);
      end else begin
        want = pending_values.pop_front();
        if (out_if.integer_part !== want.integer_part)
          report_mismatch("integer_part", 32'(out_if.integer_part),
                          32'(want.integer_part));
        if (out_if.fraction_part !== want.fraction_part)
          report_mismatch("fraction_part", out_if.fraction_part, want.fraction_part);
        if (out_if.integer_overflow !== want.integer_overflow)
          report_mismatch("integer_overflow", 32'(out_if.integer_overflow),
                          32'(want.integer_overflow));
        if (out_if.fraction_truncated !== want.fraction_truncated)
          report_mismatch("fraction_truncated", 32'(out_if.fraction_truncated),
                          32'(want.fraction_truncated));
      end
    end
  end

  // watchdog: cycles with no request moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $realtime,
               pending_values.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.char_code  = '0;
    in_if.last_char  = 1'b0;
    out_if.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_left        = 0;
    idle_cycles      = 0;
    mismatches       = 0;
    chars_sent       = 0;
    numbers_parsed   = 0;
    clipped_seen     = 0;
    dropped_seen     = 0;
    clear_parser();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_receiver_hold_off();
    test_drain_pause();
    wait_drained();

    if (pending_values.size() != 0)
      report_mismatch("results never delivered", 32'(pending_values.size()), '0);

    $display("Parsed %0d numbers from %0d characters (%0d clipped, %0d with dropped digits)",
             numbers_parsed, chars_sent, clipped_seen, dropped_seen);
    $display("Phases: directed, streaming, sender gaps, output stalls, mixed, hold-off, drain");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
